### rtl/pdc_pkg.sv
// Package: widths, register indexes, configuration type and reset values for the PID block.
`timescale 1ns / 1ps

package pdc_pkg;

  localparam int ERR_W   = 16;
  localparam int GAIN_W  = 16;
  localparam int LIM_W   = 15;
  localparam int ACC_W   = 17;
  localparam int IDX_W   = 3;
  localparam int DATA_W  = 16;
  localparam int FRAC_W  = 8;

  typedef enum logic [IDX_W-1:0] {
    REG_GAIN_P    = 3'd0,
    REG_GAIN_I    = 3'd1,
    REG_GAIN_D    = 3'd2,
    REG_LIMIT     = 3'd3,
    REG_DEAD_ZONE = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] gain_p;
    logic signed [GAIN_W-1:0] gain_i;
    logic signed [GAIN_W-1:0] gain_d;
    logic        [LIM_W-1:0]  limit;
    logic        [LIM_W-1:0]  dead_zone;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    gain_p:    16'sd256,
    gain_i:    16'sd0,
    gain_d:    16'sd0,
    limit:     15'h7fff,
    dead_zone: 15'h0000
  };

endpackage

### rtl/pdc_if.sv
// Interfaces: input item, result item and configuration write channels.
`timescale 1ns / 1ps

interface pdc_in_if import pdc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    func;
  logic signed [ERR_W-1:0] err_in;
  modport source (output valid, func, err_in, input ready);
  modport sink   (input valid, func, err_in, output ready);
endinterface

interface pdc_out_if import pdc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [ERR_W-1:0] drive;
  logic                    in_dead_zone;
  modport source (output valid, drive, in_dead_zone, input ready);
  modport sink   (input valid, drive, in_dead_zone, output ready);
endinterface

interface pdc_cfg_if import pdc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  index;
  logic [DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/pid_deadband_clamped.sv
// Top level: PID controller with dead zone and anti-windup, registered single pass.
//
//   channel  dir  payload                    handshake
//   in_ch    in   func, err_in               valid/ready
//   out_ch   out  drive, in_dead_zone        valid/ready
//   cfg_ch   in   index, data                valid/ready, ready always high
//
// One item per cycle unless the result stalls; an accepted input is registered in the
// input stage, then its result in the output register, where it is held until taken.
// The integral/last-error loop closes through the update logic into its own registers.
// Reset (rst_n low, synchronous) clears state and valids, sets configuration to defaults.
// A stalled result holds the input stage; input ready is high when it is empty or advances.
`timescale 1ns / 1ps

module pid_deadband_clamped import pdc_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  pdc_in_if.sink    in_ch,
  pdc_out_if.source out_ch,
  pdc_cfg_if.sink   cfg_ch
);

  cfg_t                    cfg_r;
  logic signed [ACC_W-1:0] accum_r;
  logic signed [ERR_W-1:0] prev_r;
  logic                    in_valid_r;
  logic                    func_r;
  logic signed [ERR_W-1:0] err_r;
  logic                    out_valid_r;
  logic signed [ERR_W-1:0] drive_r;
  logic                    dz_r;

  logic signed [ACC_W-1:0] accum_nxt;
  logic signed [ERR_W-1:0] prev_nxt;
  logic signed [ERR_W-1:0] drive_nxt;
  logic                    dz_nxt;
  logic                    advance;

  assign advance      = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || advance;
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.drive        = drive_r;
  assign out_ch.in_dead_zone = dz_r;

  pdc_datapath u_dp (
    .cfg          (cfg_r),
    .accum        (accum_r),
    .prev_err     (prev_r),
    .func         (func_r),
    .err_in       (err_r),
    .drive        (drive_nxt),
    .in_dead_zone (dz_nxt),
    .accum_nxt    (accum_nxt),
    .prev_nxt     (prev_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_GAIN_P:    cfg_r.gain_p    <= cfg_ch.data;
        REG_GAIN_I:    cfg_r.gain_i    <= cfg_ch.data;
        REG_GAIN_D:    cfg_r.gain_d    <= cfg_ch.data;
        REG_LIMIT:     cfg_r.limit     <= cfg_ch.data[LIM_W-1:0];
        REG_DEAD_ZONE: cfg_r.dead_zone <= cfg_ch.data[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      accum_r     <= '0;
      prev_r      <= '0;
    end else begin
      if (in_ch.ready) begin
        in_valid_r <= in_ch.valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        accum_r     <= accum_nxt;
        prev_r      <= prev_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      func_r <= in_ch.func;
      err_r  <= in_ch.err_in;
    end
    if (advance) begin
      drive_r <= drive_nxt;
      dz_r    <= dz_nxt;
    end
  end

endmodule

### rtl/pdc_datapath.sv
// PID update: dead zone, integral separation and clamp, three products, shift and saturation.
`timescale 1ns / 1ps

module pdc_datapath import pdc_pkg::*; (
  input  cfg_t                    cfg,
  input  logic signed [ACC_W-1:0] accum,
  input  logic signed [ERR_W-1:0] prev_err,
  input  logic                    func,
  input  logic signed [ERR_W-1:0] err_in,
  output logic signed [ERR_W-1:0] drive,
  output logic                    in_dead_zone,
  output logic signed [ACC_W-1:0] accum_nxt,
  output logic signed [ERR_W-1:0] prev_nxt
);

  localparam int SUM_W = 35;
  localparam int SH_W  = SUM_W - FRAC_W;

  logic signed [ACC_W-1:0]    e_ext;
  logic        [ACC_W-1:0]    mag;
  logic                       dz;
  logic                       integ_en;
  logic signed [ACC_W:0]      acc_sum;
  logic signed [ACC_W:0]      lim_a;
  logic signed [ACC_W:0]      acc_clamp;
  logic signed [ACC_W-1:0]    acc_new;
  logic signed [ACC_W-1:0]    diff;
  logic signed [31:0]         p_term;
  logic signed [32:0]         i_term;
  logic signed [32:0]         d_term;
  logic signed [SUM_W-1:0]    sum;
  logic signed [SH_W-1:0]     sh;
  logic signed [SH_W-1:0]     lim_o;
  logic signed [SH_W-1:0]     res;

  always_comb begin
    e_ext    = {err_in[ERR_W-1], err_in};
    mag      = e_ext[ACC_W-1] ? ACC_W'(-e_ext) : e_ext;
    dz       = mag < {2'b00, cfg.dead_zone};
    integ_en = {mag, 1'b0} < {3'b000, cfg.limit};

    // integral with clamp to +-limit
    acc_sum = {accum[ACC_W-1], accum} + {e_ext[ACC_W-1], e_ext};
    lim_a   = signed'({3'b000, cfg.limit});
    if (acc_sum > lim_a) begin
      acc_clamp = lim_a;
    end else if (acc_sum < -lim_a) begin
      acc_clamp = -lim_a;
    end else begin
      acc_clamp = acc_sum;
    end
    acc_new = integ_en ? acc_clamp[ACC_W-1:0] : accum;

    diff   = e_ext - {prev_err[ERR_W-1], prev_err};
    p_term = cfg.gain_p * err_in;
    i_term = cfg.gain_i * acc_new;
    d_term = cfg.gain_d * diff;
    sum    = SUM_W'(p_term) + SUM_W'(i_term) + SUM_W'(d_term);

    // arithmetic shift: floor of the Q8.8 product sum
    sh    = sum[SUM_W-1:FRAC_W];
    lim_o = signed'({12'd0, cfg.limit});
    if (sh > lim_o) begin
      res = lim_o;
    end else if (sh < -lim_o) begin
      res = -lim_o;
    end else begin
      res = sh;
    end

    if (func || dz) begin
      drive     = '0;
      accum_nxt = '0;
      prev_nxt  = '0;
    end else begin
      drive     = res[ERR_W-1:0];
      accum_nxt = acc_new;
      prev_nxt  = err_in;
    end
    in_dead_zone = !func && dz;
  end

endmodule
